[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files of this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif
`endif

[rtl/core/dktpq_pkg.sv]
// ----------------------------------------------------------------------------
// dktpq_pkg
// Types, codes and the date check shared by the queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dktpq_pkg;
  localparam int unsigned CapacityDef = 16;
  localparam int unsigned TagW  = 16;
  localparam int unsigned PrioW = 16;
  localparam int unsigned DateW = 23;

  typedef enum logic [2:0] {
    REQ_INSERT     = 3'd0,
    REQ_POP_PRIO   = 3'd1,
    REQ_POP_DUE    = 3'd2,
    REQ_CHG_DUE    = 3'd3,
    REQ_CHG_PRIO   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_DATE = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // list operation codes
  typedef enum logic [1:0] {
    LOP_INS  = 2'd0,
    LOP_POP  = 2'd1,
    LOP_DEL  = 2'd2,
    LOP_NONE = 2'd3
  } lop_e;

  typedef struct packed {
    logic          go;
    lop_e          op;
    logic [TagW-1:0] tag;
  } lcmd_t;

  // Leap test: quotient and remainder of the year by 100 from a reciprocal
  // multiply, then the low bits of each decide.
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] q100;
    logic [13:0] r100;
    logic [27:0] prod;
    prod = y * 14'd655;  // (y*655)>>16 is y/100 or one below it, then step up
    q100 = {2'b00, prod[27:16]};
    r100 = y - 14'(q100 * 7'd100);
    if (r100 >= 14'd100) begin
      r100 = r100 - 14'd100;
      q100 = q100 + 14'd1;
    end
    is_leap = (y[1:0] == 2'b00 && r100 != 14'd0) ||
              (r100 == 14'd0 && q100[1:0] == 2'b00);
  endfunction

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y);
    logic [4:0] lim;
    lim = 5'd0;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: lim = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
      4'd2: lim = is_leap(y) ? 5'd29 : 5'd28;
      default: lim = 5'd0;
    endcase
    date_ok = (d != 5'd0) && (d <= lim);
  endfunction
endpackage
`default_nettype wire

[rtl/core/dktpq_list.sv]
// ----------------------------------------------------------------------------
// dktpq_list
// Sorted list of tag/key pairs held as a shifting chain of cells. Each
// command compares every cell at once; the cells are registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dktpq_list import dktpq_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned KeyW     = PrioW,
  parameter logic [KeyW-1:0] Bias = '0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lcmd_t           cmd_i,
  input  wire logic [KeyW-1:0] key_i,
  output logic                 empty_o,
  output logic                 full_o,
  output logic                 hit_o,
  output logic [TagW-1:0]      front_o
);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [TagW-1:0] tag_q [Capacity];
  logic [KeyW-1:0] key_q [Capacity];
  logic [CntW-1:0] cnt_q;

  logic [Capacity-1:0] used, match, first, before_ins, gt;

  // per-cell compare
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      used[i]  = CntW'(i) < cnt_q;
      match[i] = used[i] && tag_q[i] == cmd_i.tag;
      gt[i]    = used[i] && ((key_q[i] ^ Bias) >= (key_i ^ Bias));
    end
  end

  // first match: prefix of earlier matches
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < Capacity; i++) begin
      first[i] = match[i] && !seen;
      before_ins[i] = seen;
      seen = seen | match[i];
    end
  end

  assign hit_o   = |match;
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == CntW'(Capacity);
  assign front_o = tag_q[0];

  // shift cells for insert or remove
  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      for (int i = 0; i < Capacity; i++) begin
        unique case (cmd_i.op)
          LOP_INS: begin
            if (gt[i] || !used[i]) begin
              if (i == 0 || !(gt[i-((i>0)?1:0)] || !used[i-((i>0)?1:0)])) begin
                tag_q[i] <= cmd_i.tag;
                key_q[i] <= key_i;
              end else begin
                tag_q[i] <= tag_q[i-((i>0)?1:0)];
                key_q[i] <= key_q[i-((i>0)?1:0)];
              end
            end
          end
          LOP_POP, LOP_DEL: begin
            if (i + 1 < Capacity) begin
              if ((cmd_i.op == LOP_POP) || before_ins[i] || first[i]) begin
                tag_q[i] <= tag_q[(i + 1 < Capacity) ? i + 1 : i];
                key_q[i] <= key_q[(i + 1 < Capacity) ? i + 1 : i];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // track fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.go) begin
      unique case (cmd_i.op)
        LOP_INS: if (!full_o) cnt_q <= cnt_q + 1'b1;
        LOP_POP: if (!empty_o) cnt_q <= cnt_q - 1'b1;
        LOP_DEL: if (hit_o) cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(Capacity), "list count overflow")
  `ASSERT_NEVER(a_ins_full, clk_i, rst_ni, cmd_i.go && cmd_i.op == LOP_INS && full_o, "insert into full list")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_i.go && cmd_i.op == LOP_POP && empty_o, "pop of empty list")
endmodule
`default_nettype wire

[rtl/core/dual_key_task_priority_queue.sv]
// ----------------------------------------------------------------------------
// dual_key_task_priority_queue
// Two sorted tag lists, by priority and by deadline, under a short sequencer.
// ----------------------------------------------------------------------------
// S_IDLE checks a request and issues its first list commands, S_TWO any
// follow-up (to the other list after a pop, to the same list after a
// change) and S_OUT shows the result. busy_o is high in S_TWO and S_OUT.
// The result beat is shown for one cycle on done_o and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
module dual_key_task_priority_queue import dktpq_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] task_tag_i,
  input  wire logic signed [15:0] priority_req_i,
  input  wire logic [4:0]  day_i,
  input  wire logic [3:0]  month_i,
  input  wire logic [13:0] year_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [15:0]      done_tag_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TWO  = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [15:0] prio_q;
  logic [DateW-1:0] date_q;
  logic [1:0]  st_q, st_d;
  logic [15:0] dtag_q, dtag_d;
  logic        second_prio_q, second_prio_d;
  lop_e        second_op_q, second_op_d;
  logic [15:0] second_tag_q, second_tag_d;

  lcmd_t pcmd, dcmd;
  logic [PrioW-1:0] pkey;
  logic [DateW-1:0] dkey;
  logic p_empty, p_full, p_hit, d_empty, d_full, d_hit;
  logic [15:0] p_front, d_front;
  logic accept;

  assign accept = start_i && state_q == S_IDLE;
  assign busy_o = state_q != S_IDLE;

  // sequencer and list commands
  always_comb begin
    logic ok;
    state_d = state_q;
    st_d = st_q;
    dtag_d = dtag_q;
    second_prio_d = second_prio_q;
    second_op_d = second_op_q;
    second_tag_d = second_tag_q;
    pcmd = '{go: 1'b0, op: LOP_NONE, tag: task_tag_i};
    dcmd = '{go: 1'b0, op: LOP_NONE, tag: task_tag_i};
    pkey = priority_req_i;
    dkey = {year_i, month_i, day_i};
    ok = date_ok(day_i, month_i, year_i);
    unique case (state_q)
      S_IDLE: if (start_i) begin
        st_d = ST_OK;
        dtag_d = '0;
        second_op_d = LOP_NONE;
        second_tag_d = task_tag_i;
        state_d = S_TWO;
        priority case (req_type_i)
          REQ_INSERT: begin
            if (!ok) st_d = ST_BAD_DATE;
            else if (p_full || d_full) st_d = ST_FULL;
            else begin
              pcmd = '{go: 1'b1, op: LOP_INS, tag: task_tag_i};
              dcmd = '{go: 1'b1, op: LOP_INS, tag: task_tag_i};
            end
          end
          REQ_POP_PRIO: begin
            if (p_empty) st_d = ST_EMPTY;
            else begin
              dtag_d = p_front;
              pcmd = '{go: 1'b1, op: LOP_POP, tag: task_tag_i};
              second_prio_d = 1'b0;
              second_op_d = LOP_DEL;
              second_tag_d = p_front;
            end
          end
          REQ_POP_DUE: begin
            if (d_empty) st_d = ST_EMPTY;
            else begin
              dtag_d = d_front;
              dcmd = '{go: 1'b1, op: LOP_POP, tag: task_tag_i};
              second_prio_d = 1'b1;
              second_op_d = LOP_DEL;
              second_tag_d = d_front;
            end
          end
          REQ_CHG_DUE: begin
            if (!ok) st_d = ST_BAD_DATE;
            else if (!d_hit && d_full) st_d = ST_FULL;
            else begin
              dcmd = '{go: 1'b1, op: LOP_DEL, tag: task_tag_i};
              second_prio_d = 1'b0;
              second_op_d = LOP_INS;
            end
          end
          REQ_CHG_PRIO: begin
            if (!p_hit && p_full) st_d = ST_FULL;
            else begin
              pcmd = '{go: 1'b1, op: LOP_DEL, tag: task_tag_i};
              second_prio_d = 1'b1;
              second_op_d = LOP_INS;
            end
          end
          default: ;
        endcase
      end
      S_TWO: begin
        // issue the follow-up command, if any, to the list named by second_prio_q
        pkey = prio_q;
        dkey = date_q;
        if (second_op_q != LOP_NONE) begin
          if (second_prio_q) pcmd = '{go: 1'b1, op: second_op_q, tag: second_tag_q};
          else dcmd = '{go: 1'b1, op: second_op_q, tag: second_tag_q};
        end
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // hold request and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prio_q <= priority_req_i;
      date_q <= {year_i, month_i, day_i};
    end
    st_q <= st_d;
    dtag_q <= dtag_d;
    second_prio_q <= second_prio_d;
    second_op_q <= second_op_d;
    second_tag_q <= second_tag_d;
  end

  assign done_o = state_q == S_OUT;
  assign status_o = st_q;
  assign done_tag_o = dtag_q;

  dktpq_list #(.Capacity(Capacity), .KeyW(PrioW), .Bias(16'h8000)) u_prio (
    .clk_i, .rst_ni, .cmd_i(pcmd), .key_i(pkey),
    .empty_o(p_empty), .full_o(p_full), .hit_o(p_hit), .front_o(p_front)
  );

  dktpq_list #(.Capacity(Capacity), .KeyW(DateW), .Bias('0)) u_due (
    .clk_i, .rst_ni, .cmd_i(dcmd), .key_i(dkey),
    .empty_o(d_empty), .full_o(d_full), .hit_o(d_hit), .front_o(d_front)
  );

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_out_follows, clk_i, rst_ni, state_q == S_TWO |=> done_o, "missing result beat")
  `ASSERT_IMPL(a_one_hot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_IMPL(a_tag_zero, clk_i, rst_ni, done_o && status_o != ST_OK |-> done_tag_o == '0, "tag on failed request")
endmodule
`default_nettype wire

[tb/tb_dual_key_task_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_key_task_priority_queue
// Drives insert, pop and change requests into the two-list task queue and
// checks each result beat against a local shadow of both sorted lists.
// ----------------------------------------------------------------------------
module tb_dual_key_task_priority_queue;
  import dktpq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [2:0] ReqSpareFirst = 3'd5;

  typedef struct {
    logic [2:0]         req;
    logic [15:0]        tag;
    logic signed [15:0] prio;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    bit                 typed;
    status_e            st;
    logic [15:0]        dtag;
  } row_t;

  typedef struct {
    status_e     st;
    logic [15:0] dtag;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [2:0] req_type_i = '0;
  logic [15:0] task_tag_i = '0;
  logic signed [15:0] priority_req_i = '0;
  logic [4:0] day_i = '0;
  logic [3:0] month_i = '0;
  logic [13:0] year_i = '0;
  logic busy_o, done_o;
  logic [1:0] status_o;
  logic [15:0] done_tag_o;

  // shadow of both lists
  logic [15:0]        by_prio_tag[Depth];
  logic signed [15:0] by_prio_key[Depth];
  logic [15:0]        by_due_tag[Depth];
  logic [22:0]        by_due_key[Depth];
  int unsigned        prio_used, due_used;

  answer_t pending_q[$];
  row_t    directed_q[$];
  int errors, beats_seen, n_full, n_empty, n_bad, n_pops;
  int idle_pct;

  dual_key_task_priority_queue i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .task_tag_i,
    .priority_req_i, .day_i, .month_i, .year_i, .done_o, .status_o,
    .done_tag_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_dual_key_task_priority_queue NOT OK");
    $finish;
  end

  function automatic int unsigned days_in(input logic [3:0] m, input logic [13:0] y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      4'd2: return leap ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic bit valid_date(input logic [4:0] d, input logic [3:0] m,
                                    input logic [13:0] y);
    return d != 0 && d <= days_in(m, y);
  endfunction

  // Drop entry i of a list; an index past the end does nothing
  function automatic void drop_prio(input int unsigned i);
    if (i >= prio_used) return;
    for (int unsigned j = i; j + 1 < prio_used; j++) begin
      by_prio_tag[j] = by_prio_tag[j+1];
      by_prio_key[j] = by_prio_key[j+1];
    end
    prio_used--;
  endfunction

  function automatic void drop_due(input int unsigned i);
    if (i >= due_used) return;
    for (int unsigned j = i; j + 1 < due_used; j++) begin
      by_due_tag[j] = by_due_tag[j+1];
      by_due_key[j] = by_due_key[j+1];
    end
    due_used--;
  endfunction

  // Place ahead of equal keys
  function automatic void place_prio(input logic [15:0] tag, input logic signed [15:0] k);
    int unsigned pos;
    pos = 0;
    if (prio_used >= Depth) return;
    while (pos < prio_used && by_prio_key[pos] < k) pos++;
    for (int unsigned j = prio_used; j > pos; j--) begin
      by_prio_tag[j] = by_prio_tag[j-1];
      by_prio_key[j] = by_prio_key[j-1];
    end
    by_prio_tag[pos] = tag;
    by_prio_key[pos] = k;
    prio_used++;
  endfunction

  function automatic void place_due(input logic [15:0] tag, input logic [22:0] k);
    int unsigned pos;
    pos = 0;
    if (due_used >= Depth) return;
    while (pos < due_used && by_due_key[pos] < k) pos++;
    for (int unsigned j = due_used; j > pos; j--) begin
      by_due_tag[j] = by_due_tag[j-1];
      by_due_key[j] = by_due_key[j-1];
    end
    by_due_tag[pos] = tag;
    by_due_key[pos] = k;
    due_used++;
  endfunction

  function automatic int unsigned find_prio(input logic [15:0] tag);
    for (int unsigned i = 0; i < prio_used; i++) if (by_prio_tag[i] == tag) return i;
    return prio_used;
  endfunction

  function automatic int unsigned find_due(input logic [15:0] tag);
    for (int unsigned i = 0; i < due_used; i++) if (by_due_tag[i] == tag) return i;
    return due_used;
  endfunction

  // Advance the shadow lists by one request and return its answer
  function automatic answer_t apply_request(input row_t r);
    answer_t a;
    int unsigned i;
    logic [22:0] dkey;
    a.st = ST_OK;
    a.dtag = '0;
    dkey = {r.year, r.month, r.day};
    case (r.req)
      REQ_INSERT: begin
        if (!valid_date(r.day, r.month, r.year)) a.st = ST_BAD_DATE;
        else if (prio_used >= Depth || due_used >= Depth) a.st = ST_FULL;
        else begin
          place_prio(r.tag, r.prio);
          place_due(r.tag, dkey);
        end
      end
      REQ_POP_PRIO: begin
        if (prio_used == 0) a.st = ST_EMPTY;
        else begin
          a.dtag = by_prio_tag[0];
          drop_prio(0);
          drop_due(find_due(a.dtag));
        end
      end
      REQ_POP_DUE: begin
        if (due_used == 0) a.st = ST_EMPTY;
        else begin
          a.dtag = by_due_tag[0];
          drop_due(0);
          drop_prio(find_prio(a.dtag));
        end
      end
      REQ_CHG_DUE: begin
        if (!valid_date(r.day, r.month, r.year)) a.st = ST_BAD_DATE;
        else begin
          i = find_due(r.tag);
          if (i >= due_used && due_used >= Depth) a.st = ST_FULL;
          else begin
            drop_due(i);
            place_due(r.tag, dkey);
          end
        end
      end
      REQ_CHG_PRIO: begin
        i = find_prio(r.tag);
        if (i >= prio_used && prio_used >= Depth) a.st = ST_FULL;
        else begin
          drop_prio(i);
          place_prio(r.tag, r.prio);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    answer_t w;
    if (rst_ni && done_o) begin
      beats_seen++;
      if (pending_q.size() == 0) report_mismatch("unexpected beat", done_tag_o, 16'h0);
      else begin
        w = pending_q.pop_front();
        if (status_o !== w.st) report_mismatch("status", 16'(status_o), 16'(w.st));
        if (done_tag_o !== w.dtag) report_mismatch("done_tag", done_tag_o, w.dtag);
      end
    end
  end

  // Present one beat and hold it until accepted
  task automatic send(input row_t r);
    answer_t a;
    start_i        <= 1'b1;
    req_type_i     <= r.req;
    task_tag_i     <= r.tag;
    priority_req_i <= r.prio;
    day_i          <= r.day;
    month_i        <= r.month;
    year_i         <= r.year;
    do @(posedge clk_i); while (busy_o);
    a = apply_request(r);
    if (r.typed) begin
      a.st = r.st;
      a.dtag = r.dtag;
    end
    pending_q.push_back(a);
    if (a.st == ST_FULL) n_full++;
    if (a.st == ST_EMPTY) n_empty++;
    if (a.st == ST_BAD_DATE) n_bad++;
    if (a.dtag != 0) n_pops++;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic row_t mk(input logic [2:0] req, input logic [15:0] tag,
                              input logic signed [15:0] prio, input logic [4:0] d,
                              input logic [3:0] m, input logic [13:0] y,
                              input bit typed, input status_e st);
    row_t r;
    r.req = req; r.tag = tag; r.prio = prio;
    r.day = d; r.month = m; r.year = y;
    r.typed = typed; r.st = st; r.dtag = '0;
    return r;
  endfunction

  // Random beat; insert_pct biases toward filling or draining the lists
  function automatic row_t random_row(input int insert_pct);
    row_t r;
    int pick;
    r = mk(REQ_INSERT, '0, '0, 5'd1, 4'd1, '0, 1'b0, ST_OK);
    pick = $urandom_range(99);
    if (pick < insert_pct) r.req = REQ_INSERT;
    else if (pick < insert_pct + (100 - insert_pct) * 4 / 10)
      r.req = ($urandom_range(1)) ? REQ_POP_PRIO : REQ_POP_DUE;
    else if (pick < 97) r.req = ($urandom_range(1)) ? REQ_CHG_DUE : REQ_CHG_PRIO;
    else r.req = 3'($urandom_range(7, 32'(ReqSpareFirst)));
    // mostly a small tag pool so changes find their entries
    r.tag = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    r.prio = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(3));
    r.year = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(2003, 2000));
    if ($urandom_range(9) == 0) begin
      r.month = 4'($urandom);
      r.day = 5'($urandom);
    end else begin
      r.month = 4'($urandom_range(12, 1));
      r.day = 5'($urandom_range(days_in(r.month, r.year), 1));
    end
    return r;
  endfunction

  initial begin
    row_t r;
    int fill;
    prio_used = 0;
    due_used = 0;
    idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty pops, bad dates, leap years, extremes, ties
    directed_q.push_back(mk(REQ_POP_PRIO, 16'h0, 0, 5'd1, 4'd1, 14'd1, 1, ST_EMPTY));
    directed_q.push_back(mk(REQ_POP_DUE, 16'h0, 0, 5'd1, 4'd1, 14'd1, 1, ST_EMPTY));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 0, 5'd1, 4'd0, 14'd2000, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 0, 5'd0, 4'd1, 14'd2000, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 0, 5'd1, 4'd13, 14'd2000, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 0, 5'd29, 4'd2, 14'd1900, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 0, 5'd31, 4'd4, 14'd2023, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_INSERT, 16'h1, 5, 5'd29, 4'd2, 14'd2000, 1, ST_OK));
    directed_q.push_back(mk(REQ_INSERT, 16'h2, -32768, 5'd29, 4'd2, 14'd2024, 1, ST_OK));
    directed_q.push_back(mk(REQ_INSERT, 16'hFFFF, 32767, 5'd31, 4'd12, 14'h3FFF, 1, ST_OK));
    directed_q.push_back(mk(REQ_INSERT, 16'h4, 5, 5'd1, 4'd1, 14'd2000, 1, ST_OK));
    directed_q.push_back(mk(REQ_INSERT, 16'h5, 100, 5'd29, 4'd2, 14'd2000, 1, ST_OK));
    directed_q.push_back(mk(REQ_CHG_DUE, 16'h9, 0, 5'd5, 4'd5, 14'd5, 0, ST_OK));
    directed_q.push_back(mk(REQ_CHG_DUE, 16'h1, 0, 5'd30, 4'd2, 14'd2000, 1, ST_BAD_DATE));
    directed_q.push_back(mk(REQ_CHG_PRIO, 16'h1, 0, 5'd0, 4'd0, 14'd0, 0, ST_OK));
    directed_q.push_back(mk(REQ_CHG_PRIO, 16'h4D, 7, 5'd0, 4'd0, 14'd0, 0, ST_OK));
    for (int k = 0; k < 3; k++)
      directed_q.push_back(mk(ReqSpareFirst + 3'(k), 16'h1, 0, 5'd0, 4'd0, 14'd0, 1, ST_OK));
    for (int k = 0; k < 6; k++)
      directed_q.push_back(mk((k % 2) ? REQ_POP_DUE : REQ_POP_PRIO, 16'h0, 0,
                              5'd1, 4'd1, 14'd1, 0, ST_OK));
    foreach (directed_q[k]) send(directed_q[k]);

    // random phases: no idling, heavy idling, no idling again, light idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 88 : (ph == 3) ? 16 : 0;
      for (int k = 0; k < 256; k++) begin
        fill = ((k / 64) % 2 == 0) ? 70 : 20;
        r = random_row(fill);
        send(r);
      end
      if (ph == 1) begin
        // let the queue drain completely before the next beat
        start_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
      end
    end
    start_i <= 1'b0;

    for (int k = 0; k < 1000 && pending_q.size() != 0; k++) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      errors++;
      $display("%0d expected beats never arrived", pending_q.size());
    end
    $display("Checked %0d result beats: %0d pops, %0d full, %0d empty, %0d bad dates",
             beats_seen, n_pops, n_full, n_empty, n_bad);
    if (errors == 0) begin
      $display("tb_dual_key_task_priority_queue OK");
    end else begin
      $display("tb_dual_key_task_priority_queue NOT OK");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dktpq_pkg.sv
rtl/core/dktpq_list.sv
rtl/core/dual_key_task_priority_queue.sv
tb/tb_dual_key_task_priority_queue.sv
